// ===== rtl/core/rlfe_pkg.sv =====
package rlfe_pkg;

    // item kinds carried on s_tuser
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    localparam logic [7:0] FULL_SCALE = 8'd255;

    // channel index: 0 red, 1 green, 2 blue
    localparam int          NUM_CH  = 3;
    localparam logic [1:0]  CH_LAST = 2'd2;

    // serial multiply / divide: the multiply takes one bit of the color difference per cycle
    localparam int          DIGITS     = 8;
    localparam logic [2:0]  DIGIT_LAST = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DIVSET,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/rgb_linear_fade_engine_top.sv =====
// Channel  Direction  Handshake            Payload
// s_*      in         s_tvalid / s_tready  s_tdata: color target + duration, s_tuser: kind
// m_*      out        m_tvalid / m_tready  m_tdata: duty r/g/b + fading
// cfg_*    in         cfg_valid/cfg_ready  cfg_data: common_anode
//
// Sequence: a set item, or a tick that finds no fade or ends one, is accepted, then the
// result is loaded. A tick inside a fade is accepted, then per channel a load, a shift-add
// multiply, a setup and a restoring divide run on one shared unit, then the result loads.
// Reset: rst_n clears colors, fade state and output valid; no clear pass.
// Stalls: a finished result waits in the output register while the next item is
// accepted; the engine holds in ST_DONE only if a second result is ready first.
module rgb_linear_fade_engine_top #(
    parameter int DURATION_BITS = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    // slave side
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // [7:0] target_red, [15:8] target_green, [23:16] target_blue,
    // [24+DURATION_BITS-1:24] fade_ms, zero pad above
    input  logic [24 + ((DURATION_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // [0] kind
    input  logic                                         s_tuser,
    // master side
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // [7:0] duty_red, [15:8] duty_green, [23:16] duty_blue, [24] fading, [31:25] zero
    output logic [31:0]                                  m_tdata,
    // configuration
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    // [0] common_anode
    input  logic                                         cfg_data
);
    import rlfe_pkg::*;

    localparam int ACC_W     = DURATION_BITS + DIGITS;
    localparam int ELAPSED_W = DURATION_BITS + 1;

    // control
    state_t state_reg, state_next;
    logic   s_fire;
    logic   out_load;
    logic   tick_finish;

    // fade state
    logic [7:0]               cur_reg   [NUM_CH];
    logic [7:0]               cur_next  [NUM_CH];
    logic [7:0]               start_reg [NUM_CH];
    logic [7:0]               start_next[NUM_CH];
    logic [7:0]               goal_reg  [NUM_CH];
    logic [7:0]               goal_next [NUM_CH];
    logic                     active_reg, active_next;
    logic [ELAPSED_W-1:0]     elapsed_reg, elapsed_next;
    logic [DURATION_BITS-1:0] span_reg, span_next;
    logic                     anode_reg;

    // serial arithmetic unit
    logic [1:0]               ch_reg, ch_next;
    logic [2:0]               cnt_reg, cnt_next;
    logic                     neg_reg, neg_next;
    logic [7:0]               mag_reg, mag_next;       // |goal - start|, shifted right
    logic [ACC_W-1:0]         mcand_reg, mcand_next;   // elapsed, shifted left
    logic [ACC_W-1:0]         acc_reg, acc_next;       // product
    logic [DURATION_BITS-1:0] rem_reg, rem_next;       // partial remainder
    logic [7:0]               low_reg, low_next;       // low dividend bits
    logic [7:0]               quo_reg, quo_next;       // quotient bits

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    // helpers
    logic [ELAPSED_W-1:0]     elapsed_inc;
    logic [8:0]               diff;
    logic [8:0]               diff_abs;
    logic [DURATION_BITS:0]   trial;
    logic                     trial_ge;
    logic [7:0]               quo_final;
    logic [DURATION_BITS-1:0] fade_in;
    logic [7:0]               tgt [NUM_CH];

    assign fade_in = s_tdata[24 + DURATION_BITS - 1:24];
    assign tgt[0]  = s_tdata[7:0];
    assign tgt[1]  = s_tdata[15:8];
    assign tgt[2]  = s_tdata[23:16];

    // saturating elapsed count and end-of-fade test for a tick
    assign elapsed_inc = (elapsed_reg == {ELAPSED_W{1'b1}}) ? elapsed_reg
                                                           : elapsed_reg + ELAPSED_W'(1);
    assign tick_finish = (span_reg == '0) || (elapsed_inc > {1'b0, span_reg});

    // current channel difference
    assign diff     = {1'b0, goal_reg[ch_reg]} - {1'b0, start_reg[ch_reg]};
    assign diff_abs = diff[8] ? (9'd0 - diff) : diff;

    // restoring divide step
    assign trial     = {rem_reg, low_reg[7]};
    assign trial_ge  = trial >= {1'b0, span_reg};
    assign quo_final = {quo_reg[6:0], trial_ge};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == KIND_TICK && active_reg && !tick_finish)
                        state_next = ST_LOAD;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_LOAD:   state_next = ST_MUL;
            ST_MUL:    state_next = (cnt_reg == DIGIT_LAST) ? ST_DIVSET : ST_MUL;
            ST_DIVSET: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == DIGIT_LAST)
                    state_next = (ch_reg == CH_LAST) ? ST_DONE : ST_LOAD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        s_fire    = s_tvalid && (state_reg == ST_IDLE);
        out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    end

    // datapath
    always_comb
    begin
        cur_next     = cur_reg;
        start_next   = start_reg;
        goal_next    = goal_reg;
        active_next  = active_reg;
        elapsed_next = elapsed_reg;
        span_next    = span_reg;
        ch_next      = ch_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        mcand_next   = mcand_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        low_next     = low_reg;
        quo_next     = quo_reg;

        if (s_fire)
        begin
            if (s_tuser == KIND_SET)
            begin
                // a running fade jumps to its goal, then the new one starts there
                for (int c = 0; c < NUM_CH; c++)
                begin
                    if (active_reg)
                    begin
                        cur_next[c]   = goal_reg[c];
                        start_next[c] = goal_reg[c];
                    end
                    else
                    begin
                        start_next[c] = cur_reg[c];
                    end
                    goal_next[c] = tgt[c];
                end
                span_next    = fade_in;
                elapsed_next = '0;
                active_next  = 1'b1;
                if (fade_in == '0)
                begin
                    // zero duration: done at once
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        cur_next[c]   = tgt[c];
                        start_next[c] = tgt[c];
                    end
                    active_next = 1'b0;
                    span_next   = '0;
                end
            end
            else if (active_reg)
            begin
                if (tick_finish)
                begin
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        cur_next[c]   = goal_reg[c];
                        start_next[c] = goal_reg[c];
                    end
                    active_next  = 1'b0;
                    elapsed_next = '0;
                    span_next    = '0;
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                    ch_next      = 2'd0;
                end
            end
        end

        case (state_reg)
            ST_LOAD:
            begin
                neg_next   = diff[8];
                mag_next   = diff_abs[7:0];
                mcand_next = ACC_W'(elapsed_reg[DURATION_BITS-1:0]);
                acc_next   = '0;
                cnt_next   = 3'd0;
            end
            ST_MUL:
            begin
                if (mag_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mag_next   = {1'b0, mag_reg[7:1]};
                mcand_next = {mcand_reg[ACC_W-2:0], 1'b0};
                cnt_next   = cnt_reg + 3'd1;
            end
            ST_DIVSET:
            begin
                // top bits of the product are already below the span
                rem_next = acc_reg[ACC_W-1:DIGITS];
                low_next = acc_reg[DIGITS-1:0];
                quo_next = '0;
                cnt_next = 3'd0;
            end
            ST_DIV:
            begin
                rem_next = trial_ge ? DURATION_BITS'(trial - {1'b0, span_reg})
                                    : trial[DURATION_BITS-1:0];
                low_next = {low_reg[6:0], 1'b0};
                quo_next = quo_final;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == DIGIT_LAST)
                begin
                    // quotient never exceeds |diff|, so the sum stays in range
                    cur_next[ch_reg] = neg_reg ? start_reg[ch_reg] - quo_final
                                               : start_reg[ch_reg] + quo_final;
                    ch_next = ch_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            for (int c = 0; c < NUM_CH; c++)
                out_data_next[c*8 +: 8] = anode_reg ? FULL_SCALE - cur_reg[c] : cur_reg[c];
            out_data_next[31:24] = {7'd0, active_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            elapsed_reg   <= '0;
            span_reg      <= '0;
            anode_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            ch_reg        <= 2'd0;
            cnt_reg       <= 3'd0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                cur_reg[c]   <= 8'd0;
                start_reg[c] <= 8'd0;
                goal_reg[c]  <= 8'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            elapsed_reg   <= elapsed_next;
            span_reg      <= span_next;
            out_valid_reg <= out_valid_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
            cur_reg       <= cur_next;
            start_reg     <= start_next;
            goal_reg      <= goal_next;
            if (cfg_valid)
                anode_reg <= cfg_data;
        end
    end

    // arithmetic payload, no reset
    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        mcand_reg    <= mcand_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        low_reg      <= low_next;
        quo_reg      <= quo_next;
        out_data_reg <= out_data_next;
    end

    // no fade running means the timing state is cleared
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (span_reg == '0) && (elapsed_reg == '0))
        else $error("fade timing state not cleared while idle");

    // elapsed never passes the span while a fade runs
    a_elapsed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (elapsed_reg <= {1'b0, span_reg}))
        else $error("elapsed beyond span during fade");

    // divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < span_reg))
        else $error("divide remainder out of range");

    // channel index never leaves red..blue while computing
    a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (ch_reg != 2'd3))
        else $error("channel index out of range");

    // serial work only starts on a fade tick
    a_work_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> active_reg && (span_reg != '0))
        else $error("serial unit started without a running fade");

endmodule
